// File: hdl/mjq_pkg.sv
package mjq_pkg;

	localparam int COEF_W             = 32;
	localparam int DUR_W              = 24;
	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int FRONT_LAT          = 5;
	localparam int DIV_LAT            = COEF_W + 3;

	localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] start_position;
		logic signed [COEF_W-1:0] start_velocity;
		logic signed [COEF_W-1:0] start_accel;
		logic signed [COEF_W-1:0] end_position;
		logic signed [COEF_W-1:0] end_velocity;
		logic signed [COEF_W-1:0] end_accel;
		logic [DUR_W-1:0]         duration;
	} in_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef0;
		logic signed [COEF_W-1:0] coef1;
		logic signed [COEF_W-1:0] coef2;
		logic signed [COEF_W-1:0] coef3;
		logic signed [COEF_W-1:0] coef4;
		logic signed [COEF_W-1:0] coef5;
		logic [1:0]               status;
	} out_t;

	// signed width that holds the boundary residuals b0, bt1, bt2
	function automatic int sum_width(input int g);
		int m;
		m = 2 * g + COEF_W + 2;
		if (g + COEF_W + DUR_W + 2 > m) m = g + COEF_W + DUR_W + 2;
		if (COEF_W + 2 * DUR_W + 2 > m) m = COEF_W + 2 * DUR_W + 2;
		return m + 2;
	endfunction

	// signed width of the weighted numerators
	function automatic int num_width(input int g);
		return sum_width(g) + 6;
	endfunction

	// width of the divisor 8 * d^pw
	function automatic int den_width(input int pw);
		return DUR_W * pw + 3;
	endfunction

endpackage

// File: hdl/mjq_front.sv
module mjq_front #(
	parameter int TIME_FRAC_BITS = mjq_pkg::TIME_FRAC_BITS_DEF,
	localparam int NW  = mjq_pkg::num_width(TIME_FRAC_BITS),
	localparam int D3W = mjq_pkg::den_width(3),
	localparam int D4W = mjq_pkg::den_width(4),
	localparam int D5W = mjq_pkg::den_width(5)
) (
	input  logic                 clk,
	input  logic                 en,
	input  mjq_pkg::in_t         item,
	output logic signed [NW-1:0] n3,
	output logic signed [NW-1:0] n4,
	output logic signed [NW-1:0] n5,
	output logic [D3W-1:0]       den3,
	output logic [D4W-1:0]       den4,
	output logic [D5W-1:0]       den5
);

	localparam int G     = TIME_FRAC_BITS;
	localparam int DW    = mjq_pkg::DUR_W;
	localparam int XW    = mjq_pkg::COEF_W;
	localparam int XW1   = XW + 1;
	localparam int VW    = XW + DW;
	localparam int VW1   = VW + 1;
	localparam int PW    = XW + DW + 1;
	localparam int QW2   = XW + DW + 2;
	localparam int AW    = XW + 2 * DW;
	localparam int DAW   = XW + 1 + 2 * DW;
	localparam int BW    = mjq_pkg::sum_width(G);
	localparam int D3R   = 3 * DW;
	localparam int D4R   = 4 * DW;
	localparam int D5R   = 5 * DW;
	localparam int CHUNKS = 4;

	// stage 1: differences and first products
	logic signed [XW:0]   dp_s1, da_s1;
	logic signed [XW-1:0] a0_s1;
	logic signed [VW-1:0] v0d_s1, vfd_s1;
	logic [DW-1:0]        d_s1;
	logic [2*DW-1:0]      d2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s1  <= XW1'(item.end_position) - XW1'(item.start_position);
			da_s1  <= XW1'(item.end_accel) - XW1'(item.start_accel);
			a0_s1  <= item.start_accel;
			v0d_s1 <= item.start_velocity * $signed({1'b0, item.duration});
			vfd_s1 <= item.end_velocity * $signed({1'b0, item.duration});
			d_s1   <= item.duration;
			d2_s1  <= item.duration * item.duration;
		end
	end

	// stage 2: partial products on 24-bit chunks of d^2
	logic signed [PW-1:0]  ad2_lo_s2, ad2_hi_s2;
	logic signed [QW2-1:0] dad2_lo_s2, dad2_hi_s2;
	logic [2*DW-1:0]       d3_lo_s2, d3_hi_s2, d4_ll_s2, d4_lh_s2, d4_hh_s2;
	logic signed [VW:0]    dvd_s2;
	logic signed [XW:0]    dp_s2;
	logic signed [VW-1:0]  v0d_s2;
	logic [DW-1:0]         d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ad2_lo_s2  <= a0_s1 * $signed({1'b0, d2_s1[DW-1:0]});
			ad2_hi_s2  <= a0_s1 * $signed({1'b0, d2_s1[2*DW-1:DW]});
			dad2_lo_s2 <= da_s1 * $signed({1'b0, d2_s1[DW-1:0]});
			dad2_hi_s2 <= da_s1 * $signed({1'b0, d2_s1[2*DW-1:DW]});
			d3_lo_s2   <= d2_s1[DW-1:0] * d_s1;
			d3_hi_s2   <= d2_s1[2*DW-1:DW] * d_s1;
			d4_ll_s2   <= d2_s1[DW-1:0] * d2_s1[DW-1:0];
			d4_lh_s2   <= d2_s1[DW-1:0] * d2_s1[2*DW-1:DW];
			d4_hh_s2   <= d2_s1[2*DW-1:DW] * d2_s1[2*DW-1:DW];
			dvd_s2     <= VW1'(vfd_s1) - VW1'(v0d_s1);
			dp_s2      <= dp_s1;
			v0d_s2     <= v0d_s1;
			d_s2       <= d_s1;
		end
	end

	// stage 3: sum the partials
	logic signed [AW-1:0]  ad2_s3;
	logic signed [DAW-1:0] dad2_s3;
	logic [D3R-1:0]        d3_s3;
	logic [D4R-1:0]        d4_s3;
	logic signed [VW:0]    dvd_s3;
	logic signed [XW:0]    dp_s3;
	logic signed [VW-1:0]  v0d_s3;
	logic [DW-1:0]         d_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ad2_s3  <= AW'(ad2_lo_s2) + (AW'(ad2_hi_s2) <<< DW);
			dad2_s3 <= DAW'(dad2_lo_s2) + (DAW'(dad2_hi_s2) <<< DW);
			d3_s3   <= D3R'(d3_lo_s2) + (D3R'(d3_hi_s2) << DW);
			d4_s3   <= D4R'(d4_ll_s2) + (D4R'(d4_lh_s2) << (DW + 1))
				+ (D4R'(d4_hh_s2) << (2 * DW));
			dvd_s3  <= dvd_s2;
			dp_s3   <= dp_s2;
			v0d_s3  <= v0d_s2;
			d_s3    <= d_s2;
		end
	end

	// stage 4: boundary residuals, d^5 partials
	logic signed [BW-1:0] b0_s4, bt1_s4, bt2_s4;
	logic [2*DW-1:0]      d5_p_s4 [0:CHUNKS-1];
	logic [D3R-1:0]       d3_s4;
	logic [D4R-1:0]       d4_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			b0_s4  <= (BW'(dp_s3) <<< (2 * G + 1)) - (BW'(v0d_s3) <<< (G + 1)) - BW'(ad2_s3);
			bt1_s4 <= (BW'(dvd_s3) <<< (G + 1)) - (BW'(ad2_s3) <<< 1);
			bt2_s4 <= BW'(dad2_s3) <<< 1;
			for (int k = 0; k < CHUNKS; k++) begin
				d5_p_s4[k] <= d4_s3[k*DW +: DW] * d_s3;
			end
			d3_s4 <= d3_s3;
			d4_s4 <= d4_s3;
		end
	end

	// stage 5: weighted numerators by shift and add
	logic signed [NW-1:0] b0x, bt1x, bt2x;
	logic signed [NW-1:0] n3_s5, n4_s5, n5_s5;
	logic [D3W-1:0]       den3_s5;
	logic [D4W-1:0]       den4_s5;
	logic [D5W-1:0]       den5_s5;

	assign b0x  = NW'(b0_s4);
	assign bt1x = NW'(bt1_s4);
	assign bt2x = NW'(bt2_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			n3_s5 <= (b0x <<< 4) + (b0x <<< 2) - (bt1x <<< 3) + bt2x;
			n4_s5 <= (b0x <<< 1) - (b0x <<< 5) + (bt1x <<< 4) - (bt1x <<< 1) - (bt2x <<< 1);
			n5_s5 <= (b0x <<< 3) + (b0x <<< 2) - (bt1x <<< 2) - (bt1x <<< 1) + bt2x;
			den3_s5 <= {d3_s4, 3'b000};
			den4_s5 <= {d4_s4, 3'b000};
			den5_s5 <= {D5R'(d5_p_s4[0]) + (D5R'(d5_p_s4[1]) << DW)
				+ (D5R'(d5_p_s4[2]) << (2 * DW)) + (D5R'(d5_p_s4[3]) << (3 * DW)), 3'b000};
		end
	end

	assign n3   = n3_s5;
	assign n4   = n4_s5;
	assign n5   = n5_s5;
	assign den3 = den3_s5;
	assign den4 = den4_s5;
	assign den5 = den5_s5;

endmodule

// File: hdl/mjq_div.sv
module mjq_div #(
	parameter int NUM_W = mjq_pkg::num_width(mjq_pkg::TIME_FRAC_BITS_DEF),
	parameter int DEN_W = mjq_pkg::den_width(3),
	parameter int SHIFT = mjq_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]                  den,
	output logic signed [mjq_pkg::COEF_W-1:0] coef,
	output logic                              sat
);

	localparam int QW = mjq_pkg::COEF_W;
	localparam int CW = (NUM_W + SHIFT + 2 > DEN_W + QW + 1) ? NUM_W + SHIFT + 2
		: DEN_W + QW + 1;

	// stage 1: magnitude, scale, add half divisor for rounding
	logic [NUM_W-1:0] mag;
	logic [CW-1:0]    n_s1;
	logic [DEN_W-1:0] den_s1;
	logic             neg_s1;

	assign mag = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= (CW'(mag) << (SHIFT + 1)) + CW'(den >> 1);
			den_s1 <= den;
			neg_s1 <= num[NUM_W-1];
		end
	end

	// stage 2 and one restoring step per quotient bit
	logic [CW-1:0]    rem_s  [0:QW-1];
	logic [DEN_W-1:0] den_s  [0:QW-1];
	logic [QW-1:0]    q_s    [0:QW];
	logic             neg_s  [0:QW];
	logic             over_s [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= n_s1;
			den_s[0]  <= den_s1;
			q_s[0]    <= '0;
			neg_s[0]  <= neg_s1;
			over_s[0] <= n_s1 >= (CW'(den_s1) << QW);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int BIT = QW - 1 - j;
		logic [CW-1:0] shifted;
		logic          ge;

		assign shifted = CW'(den_s[j]) << BIT;
		assign ge      = rem_s[j] >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j+1]    <= q_s[j] | (QW'(ge) << BIT);
				neg_s[j+1]  <= neg_s[j];
				over_s[j+1] <= over_s[j];
			end
		end

		if (j < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge ? rem_s[j] - shifted : rem_s[j];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	// final stage: sign and clamp
	logic [QW-1:0]        lim;
	logic                 over_f;
	logic signed [QW-1:0] coef_s35;
	logic                 sat_s35;

	assign lim    = neg_s[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
	assign over_f = over_s[QW] || (q_s[QW] > lim);

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s35  <= over_f;
			coef_s35 <= over_f ? lim : (neg_s[QW] ? QW'(0) - q_s[QW] : q_s[QW]);
		end
	end

	assign coef = coef_s35;
	assign sat  = sat_s35;

endmodule

// File: hdl/min_jerk_quintic_coefficients.sv
// minimum-jerk quintic coefficients, fully pipelined
// pipeline: 5 front stages, then 35 divider stages, from request to result
// throughput: one request per cycle while no finished result is stalled; most of the depth
// is the restoring divider, which retires one quotient bit per stage
// reset: arst_n clears the valid bits only; datapath registers are not reset
module min_jerk_quintic_coefficients #(
	parameter int TIME_FRAC_BITS = mjq_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          traj_valid,
	output logic          traj_stall,
	input  mjq_pkg::in_t  traj,
	output logic          coefs_valid,
	input  logic          coefs_stall,
	output mjq_pkg::out_t coefs
);

	localparam int NW  = mjq_pkg::num_width(TIME_FRAC_BITS);
	localparam int D3W = mjq_pkg::den_width(3);
	localparam int D4W = mjq_pkg::den_width(4);
	localparam int D5W = mjq_pkg::den_width(5);
	localparam int XW  = mjq_pkg::COEF_W;
	localparam int LAT = mjq_pkg::FRONT_LAT + mjq_pkg::DIV_LAT;

	// terms that bypass the solve: start state and the zero-duration flag
	typedef struct packed {
		logic signed [XW-1:0] c0;
		logic signed [XW-1:0] c1;
		logic signed [XW-1:0] c2;
		logic                 zero;
	} side_t;

	// whole pipeline moves together; it only holds when a finished
	// result is waiting and the consumer stalls
	logic adv;
	assign adv        = !(coefs_valid && coefs_stall);
	assign traj_stall = !adv;

	// half of start acceleration, rounded to nearest, ties away from zero
	logic signed [XW:0] a_ext;
	logic [XW:0]        a_mag, a_half;
	side_t              side_in;

	assign a_ext  = (XW + 1)'(traj.start_accel);
	assign a_mag  = a_ext[XW] ? $unsigned(-a_ext) : $unsigned(a_ext);
	assign a_half = (a_mag + 1'b1) >> 1;

	always_comb begin
		side_in.c0   = traj.start_position;
		side_in.c1   = traj.start_velocity;
		side_in.c2   = a_ext[XW] ? XW'(0) - a_half[XW-1:0] : a_half[XW-1:0];
		side_in.zero = traj.duration == '0;
	end

	// valid bits and bypass terms ride alongside the datapath
	logic  valid_s [1:LAT];
	side_t side_s  [1:LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '{default: 1'b0};
		end else if (adv) begin
			valid_s[1] <= traj_valid;
			for (int k = 2; k <= LAT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_in;
			for (int k = 2; k <= LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// residuals, weighted numerators and divisors 8*d^3, 8*d^4, 8*d^5
	logic signed [NW-1:0] n3, n4, n5;
	logic [D3W-1:0]       den3;
	logic [D4W-1:0]       den4;
	logic [D5W-1:0]       den5;

	mjq_front #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS)
	) u_front (
		.clk (clk),
		.en  (adv),
		.item(traj),
		.n3  (n3),
		.n4  (n4),
		.n5  (n5),
		.den3(den3),
		.den4(den4),
		.den5(den5)
	);

	// one divider per solved coefficient, all with the same latency
	logic signed [XW-1:0] c3, c4, c5;
	logic                 sat3, sat4, sat5;

	mjq_div #(
		.NUM_W(NW),
		.DEN_W(D3W),
		.SHIFT(TIME_FRAC_BITS)
	) u_div3 (
		.clk (clk),
		.en  (adv),
		.num (n3),
		.den (den3),
		.coef(c3),
		.sat (sat3)
	);

	mjq_div #(
		.NUM_W(NW),
		.DEN_W(D4W),
		.SHIFT(2 * TIME_FRAC_BITS)
	) u_div4 (
		.clk (clk),
		.en  (adv),
		.num (n4),
		.den (den4),
		.coef(c4),
		.sat (sat4)
	);

	mjq_div #(
		.NUM_W(NW),
		.DEN_W(D5W),
		.SHIFT(3 * TIME_FRAC_BITS)
	) u_div5 (
		.clk (clk),
		.en  (adv),
		.num (n5),
		.den (den5),
		.coef(c5),
		.sat (sat5)
	);

	// result assembly from the last stage registers
	assign coefs_valid = valid_s[LAT];

	always_comb begin
		coefs.coef0 = side_s[LAT].c0;
		coefs.coef1 = side_s[LAT].c1;
		coefs.coef2 = side_s[LAT].c2;
		if (side_s[LAT].zero) begin
			// zero duration: solved terms forced to zero
			coefs.coef3  = '0;
			coefs.coef4  = '0;
			coefs.coef5  = '0;
			coefs.status = mjq_pkg::ST_ZERO;
		end else begin
			coefs.coef3  = c3;
			coefs.coef4  = c4;
			coefs.coef5  = c5;
			coefs.status = (sat3 || sat4 || sat5) ? mjq_pkg::ST_SAT : mjq_pkg::ST_OK;
		end
	end

endmodule

// File: hdl/mjq_checker.sv
module mjq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          traj_stall,
	input logic          coefs_valid,
	input logic          coefs_stall,
	input mjq_pkg::out_t coefs
);

	// a waiting result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coefs_valid && coefs_stall |=> coefs_valid && $stable(coefs))
		else $error("result changed while stalled");

	// request side stalls exactly when the output is blocked
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		traj_stall == (coefs_valid && coefs_stall))
		else $error("request stall does not follow output stall");

	// zero duration zeroes the solved terms
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		coefs_valid && coefs.status == mjq_pkg::ST_ZERO |->
			coefs.coef3 == '0 && coefs.coef4 == '0 && coefs.coef5 == '0)
		else $error("zero duration with nonzero solved terms");

	// saturation shows up as a clamped coefficient
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		coefs_valid && coefs.status == mjq_pkg::ST_SAT |->
			coefs.coef3 == mjq_pkg::COEF_MAX || coefs.coef3 == mjq_pkg::COEF_MIN ||
			coefs.coef4 == mjq_pkg::COEF_MAX || coefs.coef4 == mjq_pkg::COEF_MIN ||
			coefs.coef5 == mjq_pkg::COEF_MAX || coefs.coef5 == mjq_pkg::COEF_MIN)
		else $error("saturation flagged with no clamped coefficient");

endmodule

bind min_jerk_quintic_coefficients mjq_checker u_mjq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.traj_stall (traj_stall),
	.coefs_valid(coefs_valid),
	.coefs_stall(coefs_stall),
	.coefs      (coefs)
);

// File: bench/mjq_checker.sv
module mjq_scoreboard (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          traj_valid,
	input  logic          traj_stall,
	input  mjq_pkg::in_t  traj,
	input  logic          coefs_valid,
	input  logic          coefs_stall,
	input  mjq_pkg::out_t coefs,
	output int            errors,
	output int            pending,
	output int            results
);

	localparam int G = mjq_pkg::TIME_FRAC_BITS_DEF;

	typedef logic signed [255:0] wide_t;

	mjq_pkg::out_t coef_queue[$];

	// round(num * 2^sh / (4 d^pw)) ties away from zero, clamp to 32 bits
	function automatic logic [31:0] round_div(input wide_t num, input int sh,
			input wide_t d, input int pw, inout logic sat);
		wide_t mag, den, q, lim;
		logic neg;
		neg = num < 0;
		mag = neg ? -num : num;
		den = 4;
		for (int k = 0; k < pw; k++) den = den * d;
		q = ((mag <<< (sh + 1)) + den) / (den <<< 1);
		lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
		if (q > lim) begin
			sat = 1'b1;
			return lim[31:0];
		end
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function automatic mjq_pkg::out_t predict_coefs(input mjq_pkg::in_t x);
		mjq_pkg::out_t r;
		wide_t p0, v0, a0, pf, vf, af, d, ad2, b0, bt1, bt2;
		logic signed [63:0] half;
		logic sat;
		p0 = x.start_position;
		v0 = x.start_velocity;
		a0 = x.start_accel;
		pf = x.end_position;
		vf = x.end_velocity;
		af = x.end_accel;
		d = {232'b0, x.duration};
		half = ((a0 < 0 ? -a0[63:0] : a0[63:0]) + 64'sd1) / 64'sd2;
		r.coef0 = x.start_position;
		r.coef1 = x.start_velocity;
		r.coef2 = 32'(a0 < 0 ? -half : half);
		r.coef3 = '0;
		r.coef4 = '0;
		r.coef5 = '0;
		if (x.duration == '0) begin
			r.status = mjq_pkg::ST_ZERO;
		end else begin
			sat = 1'b0;
			ad2 = a0 * d * d;
			b0 = ((pf - p0) <<< (2 * G + 1)) - ((v0 * d) <<< (G + 1)) - ad2;
			bt1 = (((vf - v0) * d) <<< (G + 1)) - (ad2 <<< 1);
			bt2 = ((af - a0) * d * d) <<< 1;
			r.coef3 = round_div(20 * b0 - 8 * bt1 + bt2, G, d, 3, sat);
			r.coef4 = round_div(-30 * b0 + 14 * bt1 - 2 * bt2, 2 * G, d, 4, sat);
			r.coef5 = round_div(12 * b0 - 6 * bt1 + bt2, 3 * G, d, 5, sat);
			r.status = sat ? mjq_pkg::ST_SAT : mjq_pkg::ST_OK;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		mjq_pkg::out_t want;
		if (!arst_n) begin
			coef_queue.delete();
			errors = 0;
			results = 0;
			pending = 0;
		end else begin
			if (traj_valid && !traj_stall)
				coef_queue.insert(coef_queue.size(), predict_coefs(traj));
			if (coefs_valid && !coefs_stall) begin
				results++;
				if (coef_queue.size() == 0) begin
					report("unexpected result", coefs.coef0, 32'h0);
				end else begin
					want = coef_queue.pop_front();
					if (coefs.coef0 !== want.coef0) report("coef0", coefs.coef0, want.coef0);
					if (coefs.coef1 !== want.coef1) report("coef1", coefs.coef1, want.coef1);
					if (coefs.coef2 !== want.coef2) report("coef2", coefs.coef2, want.coef2);
					if (coefs.coef3 !== want.coef3) report("coef3", coefs.coef3, want.coef3);
					if (coefs.coef4 !== want.coef4) report("coef4", coefs.coef4, want.coef4);
					if (coefs.coef5 !== want.coef5) report("coef5", coefs.coef5, want.coef5);
					if (coefs.status !== want.status)
						report("status", 32'(coefs.status), 32'(want.status));
				end
			end
			pending = coef_queue.size();
		end
	end

endmodule

// File: bench/tb.sv
module tb;

	// long enough for a full pipeline drain under the heaviest receiver stalls
	localparam int STUCK_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic          clk;
	logic          arst_n;
	logic          traj_valid;
	logic          traj_stall;
	mjq_pkg::in_t  traj;
	logic          coefs_valid;
	logic          coefs_stall;
	mjq_pkg::out_t coefs;
	int            errors;
	int            pending;
	int            results;
	int            sender_idle_pct;
	int            receiver_idle_pct;
	int            stuck_cycles;
	int            sent;

	min_jerk_quintic_coefficients u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.traj_valid  (traj_valid),
		.traj_stall  (traj_stall),
		.traj        (traj),
		.coefs_valid (coefs_valid),
		.coefs_stall (coefs_stall),
		.coefs       (coefs)
	);

	mjq_scoreboard u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.traj_valid  (traj_valid),
		.traj_stall  (traj_stall),
		.traj        (traj),
		.coefs_valid (coefs_valid),
		.coefs_stall (coefs_stall),
		.coefs       (coefs),
		.errors      (errors),
		.pending     (pending),
		.results     (results)
	);

	// free-running clock, period 10
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk) begin
		if (!arst_n)
			coefs_stall <= 1'b0;
		else
			coefs_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((traj_valid && !traj_stall) || (coefs_valid && !coefs_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending);
			$display("tb failed");
			$finish;
		end
	end

	// one request; the payload holds until accepted, stall looked at mid-cycle
	task automatic send_traj(input mjq_pkg::in_t x);
		logic taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			traj_valid <= 1'b0;
			@(posedge clk);
		end
		traj <= x;
		traj_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !traj_stall;
			@(posedge clk);
		end
		sent++;
	endtask

	// hold off until the pipeline has handed back everything
	task automatic drain();
		traj_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_q16();
		// shift spreads magnitudes from full scale down to tiny
		return $signed($urandom) >>> $urandom_range(31);
	endfunction

	function automatic mjq_pkg::in_t make_traj(input logic plausible);
		mjq_pkg::in_t x;
		if (plausible) begin
			// moderate states so most coefficients stay in range
			x.start_position = $signed($urandom) >>> $urandom_range(8, 31);
			x.start_velocity = $signed($urandom) >>> $urandom_range(10, 31);
			x.start_accel    = $signed($urandom) >>> $urandom_range(10, 31);
			x.end_position   = $signed($urandom) >>> $urandom_range(8, 31);
			x.end_velocity   = $signed($urandom) >>> $urandom_range(10, 31);
			x.end_accel      = $signed($urandom) >>> $urandom_range(10, 31);
			x.duration       = 24'($urandom_range(32'h0000_4000, 32'h000A_0000));
		end else begin
			x.start_position = rand_q16();
			x.start_velocity = rand_q16();
			x.start_accel    = rand_q16();
			x.end_position   = rand_q16();
			x.end_velocity   = rand_q16();
			x.end_accel      = rand_q16();
			case ($urandom_range(3))
				0: x.duration = '0;
				1: x.duration = 24'($urandom_range(1, 16));
				default: x.duration = 24'($urandom);
			endcase
		end
		return x;
	endfunction

	function automatic mjq_pkg::in_t fill_traj(input logic signed [31:0] v,
			input logic [23:0] dur);
		mjq_pkg::in_t x;
		x.start_position = v;
		x.start_velocity = v;
		x.start_accel    = v;
		x.end_position   = v;
		x.end_velocity   = v;
		x.end_accel      = v;
		x.duration       = dur;
		return x;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_traj(make_traj($urandom_range(99) < 80));
	endtask

	initial begin
		mjq_pkg::in_t x;
		arst_n = 1'b0;
		traj_valid = 1'b0;
		traj = '0;
		sent = 0;
		sender_idle_pct = 23;
		receiver_idle_pct = 85;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero duration, extremes, rounding ties of coef2
		send_traj(fill_traj(32'sh0, 24'h0));
		send_traj(fill_traj(32'sh7FFF_FFFF, 24'h0));
		send_traj(fill_traj(32'sh0, 24'hFF_FFFF));
		send_traj(fill_traj(32'sh7FFF_FFFF, 24'hFF_FFFF));
		send_traj(fill_traj(32'sh8000_0000, 24'hFF_FFFF));
		send_traj(fill_traj(32'sh8000_0000, 24'h1));
		send_traj(fill_traj(32'sh7FFF_FFFF, 24'h1));
		send_traj(fill_traj(32'sh1, 24'h01_0000));
		send_traj(fill_traj(-32'sh1, 24'h01_0000));
		send_traj(fill_traj(32'sh3, 24'h01_0000));
		send_traj(fill_traj(-32'sh3, 24'h02_0000));
		send_traj(fill_traj(32'sh0001_0000, 24'h00_8000));
		// rest to rest, 1.0 over 1.0 s
		x = fill_traj(32'sh0, 24'h01_0000);
		x.end_position = 32'sh0001_0000;
		send_traj(x);
		// saturation in both directions
		x = fill_traj(32'sh0, 24'h1);
		x.end_position = 32'sh7FFF_FFFF;
		x.start_position = 32'sh8000_0000;
		send_traj(x);
		x.end_position = 32'sh8000_0000;
		x.start_position = 32'sh7FFF_FFFF;
		send_traj(x);
		// only accelerations differ
		x = fill_traj(32'sh0, 24'h03_0000);
		x.start_accel = 32'sh0002_0000;
		x.end_accel = -32'sh0002_0000;
		send_traj(x);
		// long maneuver, small displacement
		x = fill_traj(32'sh0, 24'hFF_0000);
		x.end_position = 32'sh0000_0010;
		x.end_velocity = -32'sh0000_0003;
		send_traj(x);

		run_random(130);
		drain();

		sender_idle_pct = 85;
		receiver_idle_pct = 23;
		run_random(130);
		drain();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_random(170);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d trajectory requests, %0d results checked, %0d errors",
			sent, results, errors);
		$display("covered zero and extreme durations, saturation, coef2 rounding, 3 idle mixes");
		if (errors == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/mjq_pkg.sv
hdl/mjq_front.sv
hdl/mjq_div.sv
hdl/min_jerk_quintic_coefficients.sv
hdl/mjq_checker.sv
bench/mjq_checker.sv
bench/tb.sv
